// ===== sv/hcq_pkg.sv =====
// Shared types, constants and register codes for the H.264 coefficient quantizer.
package hcq_pkg;

  // Longest coefficient group the framing counter has to cover.
  localparam int MAX_GROUP_SIZE = 64;

  // Natural group lengths of the framing modes.
  localparam int SUB_SIZE  = 16;
  localparam int FULL_SIZE = 64;

  // Width at which a group position is split into 4x4 sub-block index and offset.
  localparam int POS_W = 6;

  // APB register file: one 32-bit register, word addressed.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_MODE = 1'b0;

  // Framing mode codes held in the block_mode register.
  localparam logic [1:0] MODE_4X4  = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;
  localparam logic [1:0] MODE_8X8  = 2'd2;

  typedef struct packed {
    logic signed [15:0] coef_in;
    logic        [15:0] multiplier;
    logic        [15:0] rounding_bias;
  } coef_item_t;

  typedef struct packed {
    logic signed [15:0] level_out;
    logic               group_done;
    logic        [3:0]  nonzero_mask;
  } level_item_t;

  typedef struct packed {
    logic       group_done;
    logic [3:0] nonzero_mask;
  } frame_status_t;

endpackage

// ===== sv/hcq_stream_if.sv =====
// Valid/ready stream interface carrying one payload per transaction.
interface hcq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/h264_coefficient_quantizer.sv =====
// Top level of the H.264 deadzone coefficient quantizer with group framing.
//
//   Port group   Role     Payload / purpose
//   coef_i       sink     coef_in, multiplier, rounding_bias (one coefficient)
//   level_o      source   level_out, group_done, nonzero_mask (one result)
//   APB (p*)     slave    block_mode register at byte address 0
//
// Each coefficient passes through the input register and then the result
// register before its result is presented on level_o. A new coefficient can
// be taken in every cycle while level_o is not stalled. The path between the
// two registers is one 17x16 multiply with the magnitude/bias add before it
// and the sign restore after it. Reset clears the framing counter, the
// nonzero mask and block_mode.
// When level_o is stalled the result register holds and the input register
// fills; coef_i.ready drops only when both are occupied.
module h264_coefficient_quantizer #(
  parameter int MaxGroupSize = hcq_pkg::MAX_GROUP_SIZE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [hcq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [hcq_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  hcq_stream_if.sink                     coef_i,
  hcq_stream_if.source                   level_o
);

  logic [1:0]                block_mode;

  // Input register stage.
  logic                      s1_valid_q;
  logic                      s1_valid_d;
  hcq_pkg::coef_item_t       s1_data_q;
  hcq_pkg::coef_item_t       s1_data_d;

  // Result register stage.
  logic                      out_valid_q;
  logic                      out_valid_d;
  hcq_pkg::level_item_t      out_data_q;
  hcq_pkg::level_item_t      out_data_d;

  logic                      out_free;
  logic                      s1_adv;
  logic                      in_take;
  logic signed [15:0]        level;
  logic                      level_nonzero;
  hcq_pkg::frame_status_t    frame_status;

  hcq_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .block_mode_o (block_mode)
  );

  // The result register can take a new result when it is empty or is being
  // drained in this cycle; the input register moves forward in that case.
  assign out_free = !out_valid_q || level_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign coef_i.ready = !s1_valid_q || s1_adv;
  assign in_take  = coef_i.valid && coef_i.ready;

  hcq_level u_level (
    .coef_i          (s1_data_q.coef_in),
    .multiplier_i    (s1_data_q.multiplier),
    .rounding_bias_i (s1_data_q.rounding_bias),
    .level_o         (level),
    .nonzero_o       (level_nonzero)
  );

  // The framer advances exactly once per coefficient, as it enters the
  // result register, so its state follows transaction order.
  hcq_framer #(
    .MaxGroupSize (MaxGroupSize)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_adv),
    .block_mode_i (block_mode),
    .nonzero_i    (level_nonzero),
    .status_o     (frame_status)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_data_d  = s1_data_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
      s1_data_d  = coef_i.payload;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (s1_adv) begin
      out_valid_d             = 1'b1;
      out_data_d.level_out    = level;
      out_data_d.group_done   = frame_status.group_done;
      out_data_d.nonzero_mask = frame_status.nonzero_mask;
    end else if (level_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_data_q  <= s1_data_d;
    out_data_q <= out_data_d;
  end

  assign level_o.valid   = out_valid_q;
  assign level_o.payload = out_data_q;

  a_stall_keeps_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && (s1_data_q == $past(s1_data_q)))
    else $error("input register lost a coefficient while the result side stalled");

  a_mask_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_data_q.group_done |-> out_data_q.nonzero_mask == 4'b0000)
    else $error("nonzero mask reported outside the end of a group");

  a_take_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted coefficient did not reach the input register");

endmodule

// ===== sv/hcq_apb_regs.sv =====
// APB configuration register file holding the block_mode register.
module hcq_apb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hcq_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [hcq_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [hcq_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [1:0]                         block_mode_o
);

  logic [1:0]                        mode_q;
  logic [1:0]                        mode_d;
  logic [hcq_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                              wr_en;

  assign reg_idx = paddr[hcq_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && (reg_idx == hcq_pkg::REG_BLOCK_MODE);
  assign mode_d  = wr_en ? pwdata[1:0] : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= hcq_pkg::MODE_4X4;
    end else begin
      mode_q <= mode_d;
    end
  end

  always_comb begin
    if (reg_idx == hcq_pkg::REG_BLOCK_MODE) begin
      prdata = {{(hcq_pkg::APB_DATA_W-2){1'b0}}, mode_q};
    end else begin
      prdata = '0;
    end
  end

  assign block_mode_o = mode_q;

endmodule

// ===== sv/hcq_level.sv =====
// Deadzone quantization of one coefficient: magnitude, bias, multiply, sign restore.
module hcq_level (
  input  logic signed [15:0] coef_i,
  input  logic        [15:0] multiplier_i,
  input  logic        [15:0] rounding_bias_i,
  output logic signed [15:0] level_o,
  output logic               nonzero_o
);

  logic        negative;
  logic        nonpositive;
  logic [16:0] mag;
  logic [16:0] biased;
  logic [32:0] prod;
  logic [15:0] level;

  assign negative    = coef_i[15];
  assign nonpositive = negative || (coef_i == 16'sd0);

  // The magnitude of the most negative input needs the seventeenth bit.
  assign mag    = negative ? 17'(17'h10000 - {1'b0, coef_i}) : {1'b0, coef_i};
  assign biased = mag + {1'b0, rounding_bias_i};
  assign prod   = {16'b0, biased} * {17'b0, multiplier_i};
  assign level  = prod[31:16];

  assign nonzero_o = (level != 16'd0);
  assign level_o   = nonpositive ? $signed(16'(16'd0 - level)) : $signed(level);

endmodule

// ===== sv/hcq_framer.sv =====
// Group framing: position counter and per-sub-block nonzero mask accumulation.
module hcq_framer #(
  parameter int MaxGroupSize = hcq_pkg::MAX_GROUP_SIZE
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [1:0]             block_mode_i,
  input  logic                   nonzero_i,
  output hcq_pkg::frame_status_t status_o
);

  localparam int CntW  = $clog2(MaxGroupSize);
  localparam int Len16 = (hcq_pkg::SUB_SIZE < MaxGroupSize) ? hcq_pkg::SUB_SIZE : MaxGroupSize;
  localparam int Len64 = (hcq_pkg::FULL_SIZE < MaxGroupSize) ? hcq_pkg::FULL_SIZE
                                                               : MaxGroupSize;

  logic [CntW-1:0]          count_q;
  logic [CntW-1:0]          count_d;
  logic [3:0]               mask_q;
  logic [3:0]               mask_d;
  logic [CntW:0]            group_len;
  logic [hcq_pkg::POS_W-1:0] pos_ext;
  logic [3:0]               pos_bit;
  logic [3:0]               mask_next;
  logic                     done;

  always_comb begin
    case (block_mode_i)
      hcq_pkg::MODE_QUAD: group_len = (CntW+1)'(Len64);
      hcq_pkg::MODE_8X8:  group_len = (CntW+1)'(Len64);
      default:            group_len = (CntW+1)'(Len16);
    endcase
  end

  assign pos_ext = hcq_pkg::POS_W'(count_q);
  assign pos_bit = (block_mode_i == hcq_pkg::MODE_QUAD) ? (4'b0001 << pos_ext[5:4]) : 4'b0001;
  assign mask_next = mask_q | (nonzero_i ? pos_bit : 4'b0000);

  // A lowered group length after a mode change ends the group at once.
  assign done = (({1'b0, count_q} + (CntW+1)'(1)) >= group_len);

  always_comb begin
    count_d = count_q;
    mask_d  = mask_q;
    if (step_i) begin
      if (done) begin
        count_d = '0;
        mask_d  = '0;
      end else begin
        count_d = count_q + CntW'(1);
        mask_d  = mask_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mask_q  <= '0;
    end else begin
      count_q <= count_d;
      mask_q  <= mask_d;
    end
  end

  assign status_o.group_done   = done;
  assign status_o.nonzero_mask = done ? mask_next : 4'b0000;

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done |=> (count_q == '0) && (mask_q == 4'b0000))
    else $error("framer state not cleared after end of group");

  a_count_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !done |=> count_q == CntW'($past(count_q) + CntW'(1)))
    else $error("framer position did not advance by one");

  a_mask_keeps_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !done |=> ((mask_q & $past(mask_q)) == $past(mask_q)))
    else $error("framer mask lost a bit within a group");

endmodule
